// ===== design/ntts_pkg.sv =====
package ntts_pkg;

  localparam int MAX_NOTES_DEF = 64;

  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 6;
  localparam int PERIOD_W = 16;
  localparam int LENGTH_W = 16;
  localparam int COUNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 3'd0,
    KIND_PLAY = 3'd1,
    KIND_STOP = 3'd2,
    KIND_TONE = 3'd3,
    KIND_BEAT = 3'd4
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [INDEX_W-1:0]  entry_index;
    logic [PERIOD_W-1:0] entry_period;
    logic [LENGTH_W-1:0] entry_length;
  } item_t;

  typedef struct packed {
    logic               speaker_level;
    logic               playing;
    logic [INDEX_W-1:0] note_index;
    logic               finished;
  } result_t;

endpackage

// ===== design/note_table_tone_sequencer_top.sv =====
// Note table tone sequencer: plays a loaded table of notes as a square wave.
// Item channel (item_valid / item_stall / item): one word per event: load a
// table entry, play, stop, tone tick or beat tick. Result channel
// (result_valid / result_stall / result): exactly one word per item with the
// speaker level, playing flag, current note index and a one-word finished
// pulse when the melody ran out on its own.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes note_count;
// cfg_ready is always high. Write it only while the block is idle.
// One item per clock while item_stall is low. The result word is registered and
// valid the cycle after the item is taken. The table is held in RAMs read at
// the next position every cycle, so the current period, current length and
// next period are ready when the following tick arrives.
// Reset clears position, counters, level, running and note_count; table
// entries are undefined until loaded.
// While the result register is full and result_stall is high, item_stall is
// raised and the result word holds.
module note_table_tone_sequencer_top #(
  parameter int MAX_NOTES = ntts_pkg::MAX_NOTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  ntts_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output ntts_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ntts_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int PW    = ntts_pkg::PERIOD_W;
  localparam int LW    = ntts_pkg::LENGTH_W;

  logic                        accept;
  logic [ntts_pkg::COUNT_W-1:0] note_count;

  logic [IDX_W-1:0] position, position_next;
  logic [PW-1:0]    tone_counter, tone_counter_next;
  logic [LW-1:0]    beat_counter, beat_counter_next;
  logic             running, running_next;
  logic             level, level_next;
  logic             done;

  // table write port
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  logic [IDX_W-1:0] rd_cur_addr, rd_nxt_addr;

  logic [PW-1:0] ram_cur_period, ram_nxt_period;
  logic [LW-1:0] ram_cur_length;
  logic [PW-1:0] wr_period;
  logic [LW-1:0] wr_length;
  logic          hit_cur, hit_nxt;

  logic [PW-1:0] cur_period, nxt_period;
  logic [LW-1:0] cur_length;

  logic [PW:0]      tone_inc;
  logic [PW-1:0]    half_m1;
  logic [LW-1:0]    beat_inc;
  logic [IDX_W:0]   pos_inc;

  assign accept     = item_valid && !item_stall;
  assign item_stall = result_valid && result_stall;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      note_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      note_count <= cfg_data;
    end
  end

  assign tbl_we    = accept && (item.kind == ntts_pkg::KIND_LOAD)
                     && (32'(item.entry_index) < MAX_NOTES);
  assign tbl_waddr = IDX_W'(item.entry_index);

  // read at the position that holds after this edge
  assign rd_cur_addr = position_next;
  assign rd_nxt_addr = IDX_W'(position_next + 1'b1);

  ntts_ram #(.WIDTH(PW), .DEPTH(MAX_NOTES)) u_period_cur (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (item.entry_period),
    .raddr (rd_cur_addr),
    .rdata (ram_cur_period)
  );

  ntts_ram #(.WIDTH(PW), .DEPTH(MAX_NOTES)) u_period_nxt (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (item.entry_period),
    .raddr (rd_nxt_addr),
    .rdata (ram_nxt_period)
  );

  ntts_ram #(.WIDTH(LW), .DEPTH(MAX_NOTES)) u_length (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (item.entry_length),
    .raddr (rd_cur_addr),
    .rdata (ram_cur_length)
  );

  // forward a load that lands on the address being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cur <= 1'b0;
      hit_nxt <= 1'b0;
    end else begin
      hit_cur <= tbl_we && (tbl_waddr == rd_cur_addr);
      hit_nxt <= tbl_we && (tbl_waddr == rd_nxt_addr);
    end
    if (tbl_we) begin
      wr_period <= item.entry_period;
      wr_length <= item.entry_length;
    end
  end

  assign cur_period = hit_cur ? wr_period : ram_cur_period;
  assign cur_length = hit_cur ? wr_length : ram_cur_length;
  assign nxt_period = hit_nxt ? wr_period : ram_nxt_period;

  assign tone_inc = {1'b0, tone_counter} + 1'b1;
  assign half_m1  = (cur_period >> 1) - 1'b1;
  assign beat_inc = beat_counter + 1'b1;
  assign pos_inc  = {1'b0, position} + 1'b1;

  always_comb begin
    position_next     = position;
    tone_counter_next = tone_counter;
    beat_counter_next = beat_counter;
    running_next      = running;
    level_next        = level;
    done              = 1'b0;
    if (accept) begin
      unique case (item.kind) inside
        ntts_pkg::KIND_PLAY, ntts_pkg::KIND_STOP: begin
          running_next      = (item.kind == ntts_pkg::KIND_PLAY);
          position_next     = '0;
          tone_counter_next = '0;
          beat_counter_next = '0;
          level_next        = 1'b0;
        end
        ntts_pkg::KIND_TONE: begin
          if (running) begin
            if (cur_period < PW'(2)) begin
              tone_counter_next = '0;
              level_next        = 1'b1;
            end else if (tone_inc >= {1'b0, cur_period}) begin
              // wrap to zero: high only when half-1 is zero
              tone_counter_next = '0;
              level_next        = (half_m1 == '0);
            end else begin
              tone_counter_next = tone_inc[PW-1:0];
              level_next        = (tone_inc[PW-1:0] >= half_m1);
            end
          end
        end
        ntts_pkg::KIND_BEAT: begin
          if (running) begin
            if (beat_inc != cur_length) begin
              beat_counter_next = beat_inc;
            end else begin
              beat_counter_next = '0;
              if ((32'(pos_inc) >= 32'(note_count)) || (32'(pos_inc) >= MAX_NOTES)
                  || (nxt_period == '0)) begin
                // melody over
                running_next      = 1'b0;
                position_next     = '0;
                tone_counter_next = '0;
                level_next        = 1'b0;
                done              = 1'b1;
              end else begin
                position_next     = pos_inc[IDX_W-1:0];
                tone_counter_next = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      tone_counter <= '0;
      beat_counter <= '0;
      running      <= 1'b0;
      level        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      position     <= position_next;
      tone_counter <= tone_counter_next;
      beat_counter <= beat_counter_next;
      running      <= running_next;
      level        <= level_next;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (accept) begin
      result.speaker_level <= level_next;
      result.playing       <= running_next;
      result.note_index    <= ntts_pkg::INDEX_W'(position_next);
      result.finished      <= done;
    end
  end

endmodule

// ===== design/ntts_ram.sv =====
module ntts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
